// File: rtl/sopc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopc_pkg - shared types and constants for the seed-on-path check
// Position width, edit codes, register indexes and the configuration view
// passed from the register file to the path walker.
// ----------------------------------------------------------------------------
package sopc_pkg;

    // Width of the tracked sequence positions (wraps modulo 2^POS_BITS)
    localparam int POS_BITS = 32;

    // Widths fixed by the interface
    localparam int COORD_BITS = 31;
    localparam int SLEN_BITS  = 16;
    localparam int RUN_BITS   = 30;
    localparam int KIND_BITS  = 2;

    // Wide enough to hold a coordinate or a position without loss
    localparam int EXT_BITS = (POS_BITS > COORD_BITS) ? POS_BITS : COORD_BITS;
    // Signed compare width for position + run against seed coordinates
    localparam int CMP_BITS = ((POS_BITS > COORD_BITS + 1) ? POS_BITS : COORD_BITS + 1) + 2;

    // Register file
    localparam int NUM_REGS = 7;
    localparam int IDX_BITS = 3;

    typedef enum logic [IDX_BITS-1:0] {
        REG_SEED_FIRST_START  = 3'd0,
        REG_SEED_SECOND_START = 3'd1,
        REG_SEED_LENGTH       = 3'd2,
        REG_ALIGN_FIRST_BEGIN = 3'd3,
        REG_ALIGN_FIRST_END   = 3'd4,
        REG_ALIGN_SECOND_BEGIN = 3'd5,
        REG_ALIGN_SECOND_END  = 3'd6
    } reg_idx_t;

    typedef enum logic [KIND_BITS-1:0] {
        EDIT_NONE = 2'd0,
        EDIT_INS  = 2'd1,
        EDIT_DEL  = 2'd2,
        EDIT_REP  = 2'd3
    } edit_kind_t;

    typedef logic [POS_BITS-1:0] pos_t;

    // Values derived from the registers, as seen by the path walker
    typedef struct packed {
        pos_t                  first_load;   // align_first_begin - 1
        pos_t                  second_load;  // align_second_begin - 1
        pos_t                  seed_diag;    // seed first - seed second
        logic [COORD_BITS-1:0] seed_first;   // seed start, first sequence
        logic [COORD_BITS:0]   seed_end;     // seed start + length
        logic                  bounds_ok;    // seed within alignment bounds
    } cfg_view_t;

    // Coordinate (zero-extended) to position width
    function automatic pos_t to_pos(input logic [COORD_BITS-1:0] v);
        logic [EXT_BITS-1:0] e;
        e = EXT_BITS'(v);
        return e[POS_BITS-1:0];
    endfunction

endpackage

// File: rtl/seed_on_alignment_path_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seed_on_alignment_path_check_top - seed-on-alignment-path check
// Walks an alignment edit script beat by beat and reports on the last beat
// whether a replace run covers the configured seed.
// ----------------------------------------------------------------------------
// Result: a last beat moves from the input beat register into the result
// register, which raises m_tvalid and holds the answer until it is taken.
// Throughput: one beat per cycle, set by the single registered update of the
// two positions; a blocked result holds the input only while a last beat waits.
// Reset: synchronous active-low aresetn clears the beat, script and result
// state and sets all configuration registers to zero; no clearing pass.
// ----------------------------------------------------------------------------
module seed_on_alignment_path_check_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [sopc_pkg::IDX_BITS-1:0]       cfg_index,
    input  logic [sopc_pkg::COORD_BITS-1:0]     cfg_wdata,
    // edit operations
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,  // [1:0] edit_kind, [31:2] run_length
    input  logic                                s_tlast,  // last_op
    // answers
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata   // [0] seed_inside, rest zero
);

    sopc_pkg::cfg_view_t cfg_view;
    logic                m_inside;

    sopc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_view  (cfg_view)
    );

    sopc_path_walk u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_view (cfg_view),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (sopc_pkg::edit_kind_t'(s_tdata[1:0])),
        .s_run    (s_tdata[31:2]),
        .s_last   (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_inside (m_inside)
    );

    assign m_tdata = {7'b0, m_inside};

endmodule

// File: rtl/sopc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopc_cfg_regs - configuration register file
// Holds the seed and alignment bounds and derives the diagonal, load
// values and the bounds pre-check for the path walker.
// ----------------------------------------------------------------------------
module sopc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sopc_pkg::IDX_BITS-1:0]       cfg_index,
    input  logic [sopc_pkg::COORD_BITS-1:0]     cfg_wdata,
    output sopc_pkg::cfg_view_t                 cfg_view
);

    logic [sopc_pkg::COORD_BITS-1:0] seed_first_reg;
    logic [sopc_pkg::COORD_BITS-1:0] seed_second_reg;
    logic [sopc_pkg::SLEN_BITS-1:0]  seed_len_reg;
    logic [sopc_pkg::COORD_BITS-1:0] af_begin_reg;
    logic [sopc_pkg::COORD_BITS-1:0] af_end_reg;
    logic [sopc_pkg::COORD_BITS-1:0] as_begin_reg;
    logic [sopc_pkg::COORD_BITS-1:0] as_end_reg;

    logic [sopc_pkg::COORD_BITS:0] seed_first_end;
    logic [sopc_pkg::COORD_BITS:0] seed_second_end;
    logic [sopc_pkg::COORD_BITS:0] af_end_p1;
    logic [sopc_pkg::COORD_BITS:0] as_end_p1;

    // Register writes; indexes past the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_first_reg  <= '0;
            seed_second_reg <= '0;
            seed_len_reg    <= '0;
            af_begin_reg    <= '0;
            af_end_reg      <= '0;
            as_begin_reg    <= '0;
            as_end_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                sopc_pkg::REG_SEED_FIRST_START:   seed_first_reg  <= cfg_wdata;
                sopc_pkg::REG_SEED_SECOND_START:  seed_second_reg <= cfg_wdata;
                sopc_pkg::REG_SEED_LENGTH:
                    seed_len_reg <= cfg_wdata[sopc_pkg::SLEN_BITS-1:0];
                sopc_pkg::REG_ALIGN_FIRST_BEGIN:  af_begin_reg    <= cfg_wdata;
                sopc_pkg::REG_ALIGN_FIRST_END:    af_end_reg      <= cfg_wdata;
                sopc_pkg::REG_ALIGN_SECOND_BEGIN: as_begin_reg    <= cfg_wdata;
                sopc_pkg::REG_ALIGN_SECOND_END:   as_end_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Seed end (exclusive) in each sequence, and alignment end + 1
    assign seed_first_end  = {1'b0, seed_first_reg} +
                             (sopc_pkg::COORD_BITS + 1)'(seed_len_reg);
    assign seed_second_end = {1'b0, seed_second_reg} +
                             (sopc_pkg::COORD_BITS + 1)'(seed_len_reg);
    assign af_end_p1 = {1'b0, af_end_reg} + (sopc_pkg::COORD_BITS + 1)'(1);
    assign as_end_p1 = {1'b0, as_end_reg} + (sopc_pkg::COORD_BITS + 1)'(1);

    // Derived view; end >= start + len - 1 is checked as end + 1 >= start + len
    always_comb begin
        cfg_view.first_load  = sopc_pkg::to_pos(af_begin_reg) - sopc_pkg::pos_t'(1);
        cfg_view.second_load = sopc_pkg::to_pos(as_begin_reg) - sopc_pkg::pos_t'(1);
        cfg_view.seed_diag   = sopc_pkg::to_pos(seed_first_reg) -
                               sopc_pkg::to_pos(seed_second_reg);
        cfg_view.seed_first  = seed_first_reg;
        cfg_view.seed_end    = seed_first_end;
        cfg_view.bounds_ok   = (af_begin_reg <= seed_first_reg) &&
                               (af_end_p1 >= seed_first_end) &&
                               (as_begin_reg <= seed_second_reg) &&
                               (as_end_p1 >= seed_second_end);
    end

endmodule

// File: rtl/sopc_path_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopc_path_walk - edit script walker
// Input beat register, position tracking with the replace-run coverage test,
// and the result register that carries the answer of each script.
// ----------------------------------------------------------------------------
module sopc_path_walk (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sopc_pkg::cfg_view_t               cfg_view,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  sopc_pkg::edit_kind_t              s_kind,
    input  logic [sopc_pkg::RUN_BITS-1:0]     s_run,
    input  logic                              s_last,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic                              m_inside
);

    // Input beat register
    logic                          in_valid_reg;
    sopc_pkg::edit_kind_t          in_kind_reg;
    logic [sopc_pkg::RUN_BITS-1:0] in_run_reg;
    logic                          in_last_reg;

    // Walk state
    sopc_pkg::pos_t first_pos_reg,  first_pos_next;
    sopc_pkg::pos_t second_pos_reg, second_pos_next;
    logic           hit_reg,        hit_next;
    logic           in_script_reg;

    // Result register
    logic out_valid_reg;
    logic out_inside_reg;

    logic           step_ok;
    logic           step;
    sopc_pkg::pos_t cur_first;
    sopc_pkg::pos_t cur_second;
    logic           cur_hit;
    sopc_pkg::pos_t run_pos;
    logic signed [sopc_pkg::CMP_BITS-1:0] p_ext;
    logic signed [sopc_pkg::CMP_BITS-1:0] p_plus_run;
    logic signed [sopc_pkg::CMP_BITS-1:0] p_plus_one;
    logic signed [sopc_pkg::CMP_BITS-1:0] s1_ext;
    logic signed [sopc_pkg::CMP_BITS-1:0] send_ext;
    logic           covers;

    // A held beat moves on unless it is a last beat blocked by a full result
    assign step_ok  = !in_last_reg || !out_valid_reg || m_tready;
    assign step     = in_valid_reg && step_ok;
    assign s_tready = !in_valid_reg || step_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_kind;
            in_run_reg  <= s_run;
            in_last_reg <= s_last;
        end
    end

    // Positions at the start of this beat; first beat of a script loads them
    always_comb begin
        cur_first  = in_script_reg ? first_pos_reg  : cfg_view.first_load;
        cur_second = in_script_reg ? second_pos_reg : cfg_view.second_load;
        cur_hit    = in_script_reg && hit_reg;
        run_pos    = sopc_pkg::to_pos({1'b0, in_run_reg});
    end

    // Coverage: on the seed diagonal, non-empty, and overlapping the seed
    always_comb begin
        p_ext      = sopc_pkg::CMP_BITS'($signed(cur_first));
        p_plus_run = p_ext + $signed(sopc_pkg::CMP_BITS'(in_run_reg));
        p_plus_one = p_ext + sopc_pkg::CMP_BITS'(1);
        s1_ext     = $signed(sopc_pkg::CMP_BITS'(cfg_view.seed_first));
        send_ext   = $signed(sopc_pkg::CMP_BITS'(cfg_view.seed_end));
        covers     = ((cur_first - cur_second) == cfg_view.seed_diag) &&
                     (in_run_reg != '0) &&
                     (p_plus_run >= s1_ext) && (p_plus_one < send_ext);
    end

    // Next positions and hit
    always_comb begin
        first_pos_next  = cur_first;
        second_pos_next = cur_second;
        hit_next        = cur_hit;
        unique case (in_kind_reg)
            sopc_pkg::EDIT_REP: begin
                hit_next        = cur_hit || covers;
                first_pos_next  = cur_first + run_pos;
                second_pos_next = cur_second + run_pos;
            end
            sopc_pkg::EDIT_DEL: first_pos_next  = cur_first + run_pos;
            sopc_pkg::EDIT_INS: second_pos_next = cur_second + run_pos;
            sopc_pkg::EDIT_NONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_pos_reg  <= '0;
            second_pos_reg <= '0;
            hit_reg        <= 1'b0;
            in_script_reg  <= 1'b0;
        end else if (step) begin
            first_pos_reg  <= first_pos_next;
            second_pos_reg <= second_pos_next;
            hit_reg        <= hit_next;
            in_script_reg  <= !in_last_reg;
        end
    end

    // Result register: loaded on the last beat of a script
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_last_reg) begin
            out_inside_reg <= hit_next && cfg_view.bounds_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_inside = out_inside_reg;

    // A fresh result follows only a last beat
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(step && in_last_reg))
        else $error("result without a last beat");

    // A last beat closes the script, any other keeps it open
    a_script_close: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (in_script_reg == !$past(in_last_reg)))
        else $error("script state not tracking last beats");

    // A held beat that cannot move stays held
    a_beat_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step_ok |=> in_valid_reg)
        else $error("input beat dropped");

    // A positive answer needs the bounds check to pass
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_last_reg && !cfg_view.bounds_ok |=> !out_inside_reg)
        else $error("answer set with failing bounds");

endmodule

// File: bench/seed_path_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seed_path_tb_pkg - answer prediction for the seed-on-path bench
// A bit-exact shadow of the path walker: it follows the register writes and
// every accepted edit beat, queues the answer each script should produce, and
// checks the answers coming back from the block in order.
// ----------------------------------------------------------------------------
package seed_path_tb_pkg;

    import sopc_pkg::*;

    class seed_path_tracker;
        logic [COORD_BITS-1:0] regs [NUM_REGS];
        pos_t                  first_pos;
        pos_t                  second_pos;
        bit                    hit;
        bit                    in_script;
        bit                    answers_due [$];
        int unsigned           errors;
        int unsigned           answers_seen;
        int unsigned           covered_seen;

        function new();
            foreach (regs[i]) regs[i] = '0;
            first_pos  = '0;
            second_pos = '0;
            hit        = 1'b0;
            in_script  = 1'b0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [COORD_BITS-1:0] value);
            if (idx == REG_SEED_LENGTH) begin
                regs[idx] = {{(COORD_BITS-SLEN_BITS){1'b0}}, value[SLEN_BITS-1:0]};
            end else begin
                regs[idx] = value;
            end
        endfunction

        // seed must sit inside the aligned stretch of both sequences
        function bit within_bounds();
            longint s1, s2, len;
            s1  = longint'(regs[REG_SEED_FIRST_START]);
            s2  = longint'(regs[REG_SEED_SECOND_START]);
            len = longint'(regs[REG_SEED_LENGTH]);
            if (longint'(regs[REG_ALIGN_FIRST_BEGIN]) > s1 ||
                longint'(regs[REG_ALIGN_FIRST_END]) < s1 + len - 1)
                return 1'b0;
            if (longint'(regs[REG_ALIGN_SECOND_BEGIN]) > s2 ||
                longint'(regs[REG_ALIGN_SECOND_END]) < s2 + len - 1)
                return 1'b0;
            return 1'b1;
        endfunction

        // one accepted edit beat
        function void note_edit(edit_kind_t kind, logic [RUN_BITS-1:0] run, bit last);
            pos_t   seed_diag;
            longint p;
            longint s1;
            longint s_end;
            if (!in_script) begin
                first_pos  = pos_t'(regs[REG_ALIGN_FIRST_BEGIN]) - pos_t'(1);
                second_pos = pos_t'(regs[REG_ALIGN_SECOND_BEGIN]) - pos_t'(1);
                hit        = 1'b0;
                in_script  = 1'b1;
            end
            case (kind)
                EDIT_REP: begin
                    seed_diag = pos_t'(regs[REG_SEED_FIRST_START])
                              - pos_t'(regs[REG_SEED_SECOND_START]);
                    if (!hit && pos_t'(first_pos - second_pos) == seed_diag && run != '0) begin
                        p     = $signed(first_pos);
                        s1    = longint'(regs[REG_SEED_FIRST_START]);
                        s_end = s1 + longint'(regs[REG_SEED_LENGTH]);
                        if (p + longint'(run) >= s1 && p + 1 < s_end)
                            hit = 1'b1;
                    end
                    first_pos  = first_pos + pos_t'(run);
                    second_pos = second_pos + pos_t'(run);
                end
                EDIT_DEL: first_pos  = first_pos + pos_t'(run);
                EDIT_INS: second_pos = second_pos + pos_t'(run);
                default: ;
            endcase
            if (last) begin
                answers_due.push_back(hit && within_bounds());
                in_script = 1'b0;
            end
        endfunction

        // one answer beat from the block
        function void check_answer(logic [7:0] data);
            bit want;
            answers_seen++;
            if (answers_due.size() == 0) begin
                errors++;
                $display("%0t: answer beat %b arrived with no script finished", $time, data);
                return;
            end
            want = answers_due.pop_front();
            if (want)
                covered_seen++;
            if (data[0] !== want) begin
                errors++;
                $display("%0t: seed_inside expected %b actual %b", $time, want, data[0]);
            end
            if (data[7:1] !== 7'd0) begin
                errors++;
                $display("%0t: tdata padding expected %b actual %b", $time, 7'd0, data[7:1]);
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

endpackage

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - bench for seed_on_alignment_path_check_top
// Streams edit scripts through the block under a series of seed and bounds
// settings: a short hand-built set around the coverage edges, then scripts
// steered onto the seed's diagonal mixed with raw noise. Both stream sides
// stall at random; answers are checked against a shadow of the walker.
// ----------------------------------------------------------------------------
module tb;

    import sopc_pkg::*;
    import seed_path_tb_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 4;     // margin after the last answer
    localparam int LONG_HOLD     = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int BEAT_TARGET   = 1450;
    localparam int QUIET_FROM    = 1250;
    localparam int PHASE_BEATS   = 110;

    localparam logic [RUN_BITS-1:0]   RUN_MAX   = '1;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [IDX_BITS-1:0]   cfg_index = '0;
    logic [COORD_BITS-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;    // [1:0] edit_kind, [31:2] run_length
    logic                  s_tlast   = 1'b0;  // last_op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;           // [0] seed_inside, rest zero

    seed_path_tracker sb = new();

    logic [COORD_BITS-1:0] cfg_now [NUM_REGS];
    pos_t                  walk_first;
    pos_t                  walk_second;
    int unsigned           beats_sent    = 0;
    int unsigned           scripts_sent  = 0;
    int unsigned           settings_used = 0;
    int unsigned           stall_cycles  = 0;
    bit                    idle_on       = 1'b1;
    bit                    quiet         = 1'b0;
    bit                    long_hold_req = 1'b0;

    seed_on_alignment_path_check_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // beat monitors
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_edit(edit_kind_t'(s_tdata[1:0]), s_tdata[31:2], s_tlast);
        if (aresetn && m_tvalid && m_tready)
            sb.check_answer(m_tdata);
    end

    // watchdog: cycles with no traffic at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles at %0t", stall_cycles, $time);
            $display("seed_on_alignment_path_check_top test failed");
            $finish;
        end
    end

    // answer sink: random back-pressure, one long hold on request
    initial begin : answer_sink
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (aresetn && idle_on && !quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic longint draw(int unsigned lo, int unsigned hi);
        return longint'($urandom_range(hi, lo));
    endfunction

    function automatic logic [COORD_BITS-1:0] clip_coord(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        return COORD_BITS'(v);
    endfunction

    function automatic edit_kind_t rand_kind();
        return edit_kind_t'(KIND_BITS'($urandom_range(0, 3)));
    endfunction

    function automatic logic [RUN_BITS-1:0] rand_run();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return RUN_MAX;
            2, 3:    return RUN_BITS'($urandom);
            default: return RUN_BITS'($urandom_range(0, 16));
        endcase
    endfunction

    // present one edit beat and wait for it to be taken
    task automatic send_edit(edit_kind_t kind, logic [RUN_BITS-1:0] run, bit last);
        @(negedge aclk);
        if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {run, kind};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        quiet = (beats_sent >= QUIET_FROM);
        case (kind)
            EDIT_REP: begin
                walk_first  = walk_first + pos_t'(run);
                walk_second = walk_second + pos_t'(run);
            end
            EDIT_DEL: walk_first  = walk_first + pos_t'(run);
            EDIT_INS: walk_second = walk_second + pos_t'(run);
            default: ;
        endcase
        if (last)
            scripts_sent++;
    endtask

    // stop offering, let every answer and the pipeline tail come out
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [COORD_BITS-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_now[idx] = value;
        sb.set_reg(idx, value);
    endtask

    task automatic load_config(input logic [COORD_BITS-1:0] s1, input logic [COORD_BITS-1:0] s2,
                               input logic [SLEN_BITS-1:0] len,
                               input logic [COORD_BITS-1:0] f_lo, input logic [COORD_BITS-1:0] f_hi,
                               input logic [COORD_BITS-1:0] q_lo, input logic [COORD_BITS-1:0] q_hi);
        drain();
        write_reg(REG_SEED_FIRST_START, s1);
        write_reg(REG_SEED_SECOND_START, s2);
        write_reg(REG_SEED_LENGTH, COORD_BITS'(len));
        write_reg(REG_ALIGN_FIRST_BEGIN, f_lo);
        write_reg(REG_ALIGN_FIRST_END, f_hi);
        write_reg(REG_ALIGN_SECOND_BEGIN, q_lo);
        write_reg(REG_ALIGN_SECOND_END, q_hi);
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // seed and bounds near the origin or near the top of the coordinate range;
    // now and then one bound is pulled just inside the seed
    task automatic random_config(bit high);
        longint base;
        longint s1, s2, len, f_lo, f_hi, q_lo, q_hi;
        int unsigned pick;
        base = high ? longint'(COORD_MAX) - 70000 : 0;
        s1   = base + draw(0, 3000);
        s2   = base + draw(0, 3000);
        pick = $urandom_range(0, 9);
        len  = (pick == 0) ? 0 : (pick < 8) ? draw(1, 40) : draw(41, 65535);
        f_lo = s1 - draw(0, 60);
        f_hi = s1 + len - 1 + draw(0, 60);
        q_lo = s2 - draw(0, 60);
        q_hi = s2 + len - 1 + draw(0, 60);
        case ($urandom_range(0, 11))
            0: f_lo = s1 + 1;
            1: f_hi = s1 + len - 2;
            2: q_lo = s2 + 1;
            3: q_hi = s2 + len - 2;
            default: ;
        endcase
        load_config(clip_coord(s1), clip_coord(s2), SLEN_BITS'(len), clip_coord(f_lo),
                    clip_coord(f_hi), clip_coord(q_lo), clip_coord(q_hi));
    endtask

    task automatic start_walk();
        walk_first  = pos_t'(cfg_now[REG_ALIGN_FIRST_BEGIN]) - pos_t'(1);
        walk_second = pos_t'(cfg_now[REG_ALIGN_SECOND_BEGIN]) - pos_t'(1);
    endtask

    // a script that wanders a little, steps onto the seed's diagonal and then
    // throws a replace run whose end lands around the seed's edges
    task automatic aimed_script();
        pos_t                gap;
        logic [RUN_BITS-1:0] chunk;
        longint              reach;
        int unsigned         n;
        start_walk();
        n = $urandom_range(0, 3);
        repeat (n) send_edit(rand_kind(), RUN_BITS'($urandom_range(0, 12)), 1'b0);
        if ($urandom_range(0, 4) != 0) begin
            gap = (pos_t'(cfg_now[REG_SEED_FIRST_START]) - pos_t'(cfg_now[REG_SEED_SECOND_START]))
                - (walk_first - walk_second);
            if ($signed(gap) > 0) begin
                while (gap != '0) begin
                    chunk = (gap > pos_t'(RUN_MAX)) ? RUN_MAX : gap[RUN_BITS-1:0];
                    send_edit(EDIT_DEL, chunk, 1'b0);
                    gap = gap - pos_t'(chunk);
                end
            end else begin
                gap = -gap;
                while (gap != '0) begin
                    chunk = (gap > pos_t'(RUN_MAX)) ? RUN_MAX : gap[RUN_BITS-1:0];
                    send_edit(EDIT_INS, chunk, 1'b0);
                    gap = gap - pos_t'(chunk);
                end
            end
        end
        reach = longint'(cfg_now[REG_SEED_FIRST_START]) - longint'($signed(walk_first)) - 3
              + draw(0, cfg_now[REG_SEED_LENGTH] + 6);
        if (reach < 0)
            reach = 0;
        if (reach > longint'(RUN_MAX))
            reach = longint'(RUN_MAX);
        send_edit(EDIT_REP, RUN_BITS'(reach), 1'b0);
        n = $urandom_range(0, 2);
        repeat (n) send_edit(rand_kind(), RUN_BITS'($urandom_range(0, 20)), 1'b0);
        send_edit(($urandom_range(0, 1) != 0) ? EDIT_NONE : rand_kind(),
                  RUN_BITS'($urandom_range(0, 8)), 1'b1);
    endtask

    task automatic noise_script();
        int unsigned n;
        n = $urandom_range(1, 8);
        for (int unsigned i = 0; i < n; i++)
            send_edit(rand_kind(), rand_run(), i == n - 1);
    endtask

    task automatic one_script();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            aimed_script();
        else if (pick < 9)
            noise_script();
        else
            send_edit(rand_kind(), rand_run(), 1'b1);
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned phase_start;
        foreach (cfg_now[i]) cfg_now[i] = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty marker alone is both first and last beat
        send_edit(EDIT_NONE, '0, 1'b1);

        // seed at (100, 90) length 10; walk starts at (49, 39), on its diagonal
        load_config(100, 90, 10, 50, 200, 40, 300);
        send_edit(EDIT_REP, 51, 1'b1);          // ends on seed start: covered
        send_edit(EDIT_REP, 50, 1'b1);          // stops one short
        send_edit(EDIT_DEL, 0, 1'b0);
        send_edit(EDIT_INS, 0, 1'b0);
        send_edit(EDIT_REP, 60, 1'b0);          // hit, rest of script irrelevant
        send_edit(EDIT_REP, 0, 1'b0);
        send_edit(EDIT_NONE, 0, 1'b1);
        send_edit(EDIT_INS, 1, 1'b0);           // off the diagonal
        send_edit(EDIT_REP, RUN_MAX, 1'b1);
        send_edit(EDIT_DEL, 59, 1'b0);
        send_edit(EDIT_REP, 1, 1'b1);           // starts on the seed's last position
        send_edit(EDIT_DEL, 60, 1'b0);
        send_edit(EDIT_REP, 5, 1'b1);           // starts just past the seed
        send_edit(EDIT_REP, 0, 1'b1);           // zero-length replace
        send_edit(EDIT_DEL, RUN_MAX, 1'b0);
        send_edit(EDIT_INS, RUN_MAX, 1'b0);
        send_edit(EDIT_NONE, RUN_MAX, 1'b1);

        // zero-length seed still covered; first-sequence end one short of the seed
        load_config(100, 90, 0, 50, 200, 40, 300);
        send_edit(EDIT_REP, 51, 1'b1);
        load_config(100, 90, 10, 50, 108, 40, 300);
        send_edit(EDIT_REP, 51, 1'b1);

        // random phases
        phase = 0;
        while (beats_sent < BEAT_TARGET) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case (phase)
                0:       load_config('0, '0, '0, '0, '0, '0, '0);
                1:       random_config(1'b1);
                2:       load_config(COORD_MAX, COORD_MAX, '1, COORD_MAX, COORD_MAX,
                                     COORD_MAX, COORD_MAX);
                default: random_config(phase % 4 == 1);
            endcase
            // fill the block against a stopped answer side once
            if (phase == 3)
                long_hold_req = 1'b1;
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS && beats_sent < BEAT_TARGET)
                one_script();
            phase++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d edit beats in %0d scripts under %0d register settings",
                 beats_sent, scripts_sent, settings_used);
        $display("%0d answers checked, %0d with the seed on a replace run",
                 sb.answers_seen, sb.covered_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("seed_on_alignment_path_check_top test passed");
        end else begin
            $display("seed_on_alignment_path_check_top test failed");
        end
        $finish;
    end

endmodule
